### hdl/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg: shared definitions for the maximum window sum block
// Register codes, reset values, fixed field widths and the per-item flag
// word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package mws_pkg;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 2'd3;

  localparam logic [CFG_W-1:0] RST_MATRIX_ROWS = 7'd64;
  localparam logic [CFG_W-1:0] RST_MATRIX_COLS = 7'd64;
  localparam logic [CFG_W-1:0] RST_WINDOW_ROWS = 7'd1;
  localparam logic [CFG_W-1:0] RST_WINDOW_COLS = 7'd1;

  // Result width
  localparam int OUT_W = 27;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Classification of one element
  typedef struct packed {
    logic first_col;  // column 0: restart the horizontal sum
    logic top_row;    // row 0: column sum starts from zero
    logic sub_row;    // drop the element that left the window vertically
    logic sub_col;    // drop the column sum that left the window horizontally
    logic cmp_en;     // a full window ends here
    logic last;       // last element of the matrix
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

endpackage

### hdl/max_window_sum_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_window_sum_2d: largest sliding window sum over a streamed matrix
// Elements arrive in raster order on the input channel; after the last one
// the largest window sum, floored at zero, leaves on the output channel.
// ----------------------------------------------------------------------------
// Usage:
//   Configure matrix_rows, matrix_cols, window_rows and window_cols through
//   the write port (index 0..3) while the block is idle; any write restarts
//   the matrix. Then stream matrix_rows * matrix_cols elements on
//   element_value_i with in_valid_i / in_ready_o.
//   Throughput: one element per cycle unless a waiting result stalls the
//   pipeline. Each element needs one row store read and write, one column
//   sum read-modify-write and one compare, spread over a three-stage pipeline
//   behind a four-entry queue. The last element passes the queue, two memory
//   stages, the sum stage and the result register before out_valid_o rises.
//   If the window does not fit inside the matrix, the result is 0.
//   Reset: sizes return to 64 x 64 with a 1 x 1 window, the position and the
//   best sum clear; the row store is not cleared, since only entries written
//   in the current matrix are read.
//   Stall: a result waiting for out_ready_i blocks only the next end of
//   matrix; elements keep flowing into the queue and pipeline until then.
// ----------------------------------------------------------------------------
module max_window_sum_2d #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mws_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mws_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ELEMENT_WIDTH-1:0]   element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mws_pkg::OUT_W-1:0]         best_sum_o
);
  import mws_pkg::*;

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ENTRY_W = FLAGS_W + ELEMENT_WIDTH + 2*CW + 2*(RW + CW);

  logic [CFG_W-1:0]   matrix_rows_q, matrix_cols_q, window_rows_q, window_cols_q;
  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_rows_q <= RST_MATRIX_ROWS;
      matrix_cols_q <= RST_MATRIX_COLS;
      window_rows_q <= RST_WINDOW_ROWS;
      window_cols_q <= RST_WINDOW_COLS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MATRIX_ROWS: matrix_rows_q <= cfg_data_i;
        REG_MATRIX_COLS: matrix_cols_q <= cfg_data_i;
        REG_WINDOW_ROWS: window_rows_q <= cfg_data_i;
        REG_WINDOW_COLS: window_cols_q <= cfg_data_i;
      endcase
    end
  end

  mws_front #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (cfg_we_i),
    .matrix_rows_i   (matrix_rows_q),
    .matrix_cols_i   (matrix_cols_q),
    .window_rows_i   (window_rows_q),
    .window_cols_i   (window_cols_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  mws_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  mws_back #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_sum_o  (best_sum_o)
  );

`ifndef ASSERT_OFF
  // An accepted element is in the queue in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !q_empty)
    else $error("accepted element missing from queue");

  // The back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // The front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (!q_full && in_ready_o))
    else $error("push into full queue");
`endif

endmodule

### hdl/mws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_queue: short FIFO between front end and back end
// Holds classified elements so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mws_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import mws_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      count_q;

  assign full_o  = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### hdl/mws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_front: element intake and classification
// Tracks the raster position, works out the window flags and the row store
// addresses for each element and pushes the result into the queue.
// ----------------------------------------------------------------------------
module mws_front #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        restart_i,
  input  logic [mws_pkg::CFG_W-1:0]                   matrix_rows_i,
  input  logic [mws_pkg::CFG_W-1:0]                   matrix_cols_i,
  input  logic [mws_pkg::CFG_W-1:0]                   window_rows_i,
  input  logic [mws_pkg::CFG_W-1:0]                   window_cols_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [ELEMENT_WIDTH-1:0]             element_value_i,
  input  logic                                        q_full_i,
  output logic                                        q_push_o,
  output logic [mws_pkg::FLAGS_W + ELEMENT_WIDTH
                + 2*((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)
                + 2*(((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                   + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1))-1:0] q_data_o
);
  import mws_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = RW + CW;
  localparam int PMW = (RW > CW) ? RW : CW;
  localparam int DW  = ((PMW > CFG_W) ? PMW : CFG_W) + 2;

  // Map a raw size register onto 1 .. maxv
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                               input logic [DW-1:0]    maxv);
    logic [DW-1:0] ext;
    ext = DW'(v);
    if (v == '0) begin
      return DW'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [DW-1:0] rows_lim, cols_lim, win_rows, win_cols;
  logic [DW-1:0] row_x, col_x, row_n, col_n;
  logic [DW-1:0] rd_row_x, sub_col_x;
  logic          fits, col_end, row_end;
  item_flags_t   flags;
  logic [AW-1:0] wr_addr, rd_addr;

  assign rows_lim = clamp_dim(matrix_rows_i, DW'(MAX_ROWS));
  assign cols_lim = clamp_dim(matrix_cols_i, DW'(MAX_COLS));
  assign win_rows = DW'(window_rows_i);
  assign win_cols = DW'(window_cols_i);

  assign row_x = DW'(row_q);
  assign col_x = DW'(col_q);
  assign row_n = row_x + DW'(1);
  assign col_n = col_x + DW'(1);

  assign fits = (win_rows != '0) && (win_cols != '0) &&
                (win_rows <= rows_lim) && (win_cols <= cols_lim);

  assign col_end = (col_n >= cols_lim);
  assign row_end = (row_n >= rows_lim);

  // Classify the element at the current position
  always_comb begin
    flags.first_col = (col_q == '0);
    flags.top_row   = (row_q == '0);
    flags.sub_row   = (row_x >= win_rows);
    flags.sub_col   = (col_x >= win_cols);
    flags.cmp_en    = fits && (row_n >= win_rows) && (col_n >= win_cols);
    flags.last      = col_end && row_end;
  end

  assign rd_row_x  = row_x - win_rows;
  assign sub_col_x = col_x - win_cols;
  assign wr_addr   = {row_q, col_q};
  assign rd_addr   = {rd_row_x[RW-1:0], col_q};

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = {flags, element_value_i, col_q, sub_col_x[CW-1:0], wr_addr, rd_addr};

  // Advance the raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (q_push_o) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : RW'(row_n);
      end else begin
        col_d = CW'(col_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

### hdl/mws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_back: window sum pipeline
// Three stages behind the queue: row store and column sum reads, column sum
// update, horizontal sum update; then the running maximum and the result
// register.
// ----------------------------------------------------------------------------
module mws_back #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        restart_i,
  input  logic                                        q_empty_i,
  input  logic [mws_pkg::FLAGS_W + ELEMENT_WIDTH
                + 2*((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)
                + 2*(((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                   + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1))-1:0] q_data_i,
  output logic                                        q_pop_o,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [mws_pkg::OUT_W-1:0]                   best_sum_o
);
  import mws_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW   = RW + CW;
  localparam int VW   = ELEMENT_WIDTH;
  localparam int CSW  = VW + RW + 1;
  localparam int HSW  = VW + RW + CW + 1;
  localparam int BW   = HSW - 1;
  localparam int SW   = (BW > OUT_W) ? BW : OUT_W;
  localparam int RS_DEPTH = 2 ** AW;
  localparam int CS_DEPTH = 2 ** CW;

  // Queue head fields
  item_flags_t           hd_flags;
  logic signed [VW-1:0]  hd_value;
  logic [CW-1:0]         hd_col, hd_sub_col;
  logic [AW-1:0]         hd_wr_addr, hd_rd_addr;

  assign {hd_flags, hd_value, hd_col, hd_sub_col, hd_wr_addr, hd_rd_addr} = q_data_i;

  // Storage
  logic signed [VW-1:0]  row_mem [RS_DEPTH];
  logic signed [CSW-1:0] col_mem [CS_DEPTH];

  // Stage 1
  logic                  s1_valid_q;
  item_flags_t           s1_flags_q;
  logic signed [VW-1:0]  s1_value_q;
  logic [CW-1:0]         s1_col_q, s1_sub_col_q;
  logic signed [VW-1:0]  rs_rdata_q;
  logic signed [CSW-1:0] csa_rdata_q;

  // Stage 2
  logic                  s2_valid_q;
  item_flags_t           s2_flags_q;
  logic [CW-1:0]         s2_col_q;
  logic signed [CSW-1:0] s2_newcol_q;
  logic signed [CSW-1:0] csb_rdata_q;

  // Stage 3
  logic                  s3_valid_q;
  item_flags_t           s3_flags_q;
  logic signed [HSW-1:0] hsum_q;

  // Result
  logic [BW-1:0]         best_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;

  logic                  en;
  logic signed [CSW-1:0] cs_base, cs_drop, newcol_d;
  logic signed [HSW-1:0] hs_base, hs_drop, hsum_d;
  logic [BW-1:0]         best_next;
  logic [SW-1:0]         best_ext;
  logic [OUT_W-1:0]      best_sat;
  logic                  s3_load, s3_result;

  // Freeze the whole pipeline only when a result must wait for the receiver
  assign en      = !(s3_valid_q && s3_flags_q.last && out_valid_q && !out_ready_i);
  assign q_pop_o = en && !q_empty_i;

  // Column sum update; forward the value written in the same cycle as the read
  always_comb begin
    if (s1_flags_q.top_row) begin
      cs_base = '0;
    end else if (s2_valid_q && (s2_col_q == s1_col_q)) begin
      cs_base = s2_newcol_q;
    end else begin
      cs_base = csa_rdata_q;
    end
    cs_drop  = s1_flags_q.sub_row ? CSW'(rs_rdata_q) : '0;
    newcol_d = cs_base + CSW'(s1_value_q) - cs_drop;
  end

  // Horizontal sum update
  always_comb begin
    hs_base = s2_flags_q.first_col ? '0 : hsum_q;
    hs_drop = s2_flags_q.sub_col ? HSW'(csb_rdata_q) : '0;
    hsum_d  = hs_base + HSW'(s2_newcol_q) - hs_drop;
  end

  // Running maximum and saturated result
  always_comb begin
    if (s3_flags_q.cmp_en && (hsum_q > $signed({1'b0, best_q}))) begin
      best_next = hsum_q[BW-1:0];
    end else begin
      best_next = best_q;
    end
    best_ext = SW'(best_next);
    best_sat = (best_ext > SW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : best_ext[OUT_W-1:0];
  end

  assign s3_load   = en && s3_valid_q;
  assign s3_result = s3_load && s3_flags_q.last;

  // Memories: row store write and read, column sums read at two places
  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_rdata_q  <= row_mem[hd_rd_addr];
      csa_rdata_q <= col_mem[hd_col];
      csb_rdata_q <= col_mem[s1_sub_col_q];
      if (q_pop_o) begin
        row_mem[hd_wr_addr] <= hd_value;
      end
      if (s1_valid_q) begin
        col_mem[s1_col_q] <= newcol_d;
      end
    end
  end

  // Valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= q_pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_flags_q   <= hd_flags;
      s1_value_q   <= hd_value;
      s1_col_q     <= hd_col;
      s1_sub_col_q <= hd_sub_col;
      s2_flags_q   <= s1_flags_q;
      s2_col_q     <= s1_col_q;
      s2_newcol_q  <= newcol_d;
      s3_flags_q   <= s2_flags_q;
      if (s2_valid_q) begin
        hsum_q <= hsum_d;
      end
    end
  end

  // Track the best sum; drop it at the end of a matrix or on reconfiguration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        best_q <= '0;
      end else if (s3_load) begin
        best_q <= s3_flags_q.last ? '0 : best_next;
      end
      if (s3_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until transfer
  always_ff @(posedge clk_i) begin
    if (s3_result) begin
      out_data_q <= best_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_sum_o  = out_data_q;

endmodule
